// ----- rtl/ssh_pd_pkg.sv -----
package ssh_pd_pkg;

  localparam int unsigned BUFFER_BYTES_DEFAULT = 4096;

  // Capacity register.
  localparam int unsigned        CAP_W     = 12;
  localparam logic [CAP_W-1:0]   CAP_RESET = 12'd4095;

  // APB register map: one 32-bit register per word.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [0:0]  REG_PAYLOAD_CAPACITY = 1'b0;

  // Header arithmetic after the length check fits in 17 bits,
  // since the length never exceeds 4092 there by default.
  localparam int unsigned CALC_W = 17;

  localparam int unsigned MIN_LENGTH  = 5;
  localparam int unsigned MIN_PADDING = 4;

  localparam int unsigned PAYLOAD_W = 12;
  localparam int unsigned PADDING_W = 8;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PADLEN  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_PADDING = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ERR_LENGTH   = 2'd0,
    ERR_PADDING  = 2'd1,
    ERR_CAPACITY = 2'd2
  } err_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       error;
    err_kind_t  kind;
  } result_t;

endpackage

// ----- rtl/ssh_pd_front.sv -----
module ssh_pd_front
  import ssh_pd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  input  logic [7:0]       rx_byte,
  output logic             rx_stall,
  input  logic             queue_full,
  input  logic [CAP_W-1:0] capacity,
  output logic             push,
  output result_t          item
);

  localparam logic [31:0] MaxLength = 32'(BUFFER_BYTES - 4);

  phase_t                 phase, phase_next;
  logic [31:0]            length_shift, length_shift_next;
  logic [1:0]             header_count, header_count_next;
  logic [PAYLOAD_W-1:0]   payload_left, payload_left_next;
  logic [PADDING_W-1:0]   padding_left, padding_left_next;

  logic                   accept;
  logic [31:0]            shifted;
  logic [CALC_W-1:0]      len_calc;
  logic [CALC_W-1:0]      byte_calc;
  logic [CALC_W-1:0]      plen;
  logic                   bad_length;
  logic                   bad_padding;
  logic                   over_cap;
  logic [PAYLOAD_W-1:0]   payload_dec;
  logic [PADDING_W-1:0]   padding_dec;
  logic                   last;

  assign rx_stall = queue_full;
  assign accept   = rx_valid && !queue_full;

  assign shifted    = {length_shift[23:0], rx_byte};
  assign bad_length = (shifted < 32'(MIN_LENGTH)) || (shifted > MaxLength);

  assign len_calc    = length_shift[CALC_W-1:0];
  assign byte_calc   = CALC_W'(rx_byte);
  assign bad_padding = (rx_byte < 8'(MIN_PADDING)) || ((byte_calc + 1'b1) >= len_calc);
  assign plen        = len_calc - byte_calc - 1'b1;
  assign over_cap    = plen > CALC_W'(capacity);

  assign payload_dec = (payload_left != '0) ? payload_left - 1'b1 : payload_left;
  assign padding_dec = (padding_left != '0) ? padding_left - 1'b1 : padding_left;
  assign last        = (payload_dec == '0);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        PH_LENGTH: begin
          if (header_count == 2'd3 && !bad_length) begin
            phase_next = PH_PADLEN;
          end
        end
        PH_PADLEN: begin
          phase_next = (bad_padding || over_cap) ? PH_LENGTH : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (last) begin
            phase_next = (padding_left != '0) ? PH_PADDING : PH_LENGTH;
          end
        end
        PH_PADDING: begin
          if (padding_dec == '0) begin
            phase_next = PH_LENGTH;
          end
        end
        default: phase_next = PH_LENGTH;
      endcase
    end
  end

  always_comb begin
    length_shift_next = length_shift;
    header_count_next = header_count;
    payload_left_next = payload_left;
    padding_left_next = padding_left;
    push              = 1'b0;
    item              = '{data: '0, last: 1'b0, error: 1'b0, kind: ERR_LENGTH};
    if (accept) begin
      case (phase)
        PH_LENGTH: begin
          length_shift_next = shifted;
          if (header_count != 2'd3) begin
            header_count_next = header_count + 1'b1;
          end else begin
            header_count_next = '0;
            if (bad_length) begin
              push              = 1'b1;
              item.error        = 1'b1;
              item.kind         = ERR_LENGTH;
              length_shift_next = '0;
            end
          end
        end
        PH_PADLEN: begin
          if (bad_padding) begin
            push              = 1'b1;
            item.error        = 1'b1;
            item.kind         = ERR_PADDING;
            length_shift_next = '0;
          end else if (over_cap) begin
            push              = 1'b1;
            item.error        = 1'b1;
            item.kind         = ERR_CAPACITY;
            length_shift_next = '0;
          end else begin
            payload_left_next = plen[PAYLOAD_W-1:0];
            padding_left_next = rx_byte;
          end
        end
        PH_PAYLOAD: begin
          payload_left_next = payload_dec;
          push              = 1'b1;
          item.data         = rx_byte;
          item.last         = last;
          if (last && padding_left == '0) begin
            length_shift_next = '0;
          end
        end
        PH_PADDING: begin
          padding_left_next = padding_dec;
          if (padding_dec == '0) begin
            length_shift_next = '0;
            payload_left_next = '0;
          end
        end
        default: begin
          length_shift_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LENGTH;
      length_shift <= '0;
      header_count <= '0;
      payload_left <= '0;
      padding_left <= '0;
    end else begin
      phase        <= phase_next;
      length_shift <= length_shift_next;
      header_count <= header_count_next;
      payload_left <= payload_left_next;
      padding_left <= padding_left_next;
    end
  end

  // A rejected header always sends the parser back to a clean length phase.
  a_error_restarts: assert property (@(posedge clk) disable iff (rst)
    push && item.error |=> phase == PH_LENGTH && length_shift == '0 && header_count == '0)
    else $error("parser did not restart after a frame error");

  // While payload beats flow, at least one payload byte and a legal padding remain.
  a_payload_counts: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_left != '0 && padding_left >= PADDING_W'(MIN_PADDING))
    else $error("payload phase entered with inconsistent counters");

  // The length byte counter only runs in the length phase.
  a_header_count: assert property (@(posedge clk) disable iff (rst)
    phase != PH_LENGTH |-> header_count == '0)
    else $error("header count not cleared outside the length phase");

endmodule

// ----- rtl/ssh_pd_queue.sv -----
module ssh_pd_queue
  import ssh_pd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_item,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output result_t head
);

  localparam int unsigned PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);

  result_t             entries [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr, wr_ptr_next;
  logic [PtrW-1:0]     rd_ptr, rd_ptr_next;
  logic [CountW-1:0]   count, count_next;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == CountW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // The front end holds its input while the queue is full, so no beat is dropped here.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- rtl/ssh_pd_back.sv -----
module ssh_pd_back
  import ssh_pd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  result_t    q_item,
  output logic       pop,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] payload_byte,
  output logic       last_of_payload,
  output logic       frame_error,
  output logic [1:0] error_kind
);

  logic    valid_q, valid_next;
  result_t out_item;

  assign pop        = q_valid && (!valid_q || !result_stall);
  assign valid_next = pop || (valid_q && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= q_item;
    end
  end

  assign result_valid    = valid_q;
  assign payload_byte    = out_item.data;
  assign last_of_payload = out_item.last;
  assign frame_error     = out_item.error;
  assign error_kind      = 2'(out_item.kind);

endmodule

// ----- rtl/ssh_packet_deframer.sv -----
// Streaming deframer for unencrypted SSH binary packets. One received byte is
// accepted per clock on the rx channel while rx_stall is low. Each payload
// byte is registered in the parser queue, then in the output register, and
// leaves on the result channel, with last_of_payload set on the final one.
// Length, padding-length and padding bytes give no result beat. A bad length,
// a bad padding length or a payload longer than payload_capacity gives one
// error beat, and the very next byte starts a new packet. The sustained rate
// is one byte per cycle while result_stall is low; it is set by the parser's
// header and counter updates, and a two-entry queue with the output register
// absorbs result stalls before rx_stall is raised. payload_capacity sits at
// APB address 0 and may be changed only while no packet is in flight.
module ssh_packet_deframer
  import ssh_pd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,

  input  logic              rx_valid,
  output logic              rx_stall,
  input  logic [7:0]        rx_byte,

  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        payload_byte,
  output logic              last_of_payload,
  output logic              frame_error,
  output logic [1:0]        error_kind
);

  logic [CAP_W-1:0] payload_capacity;
  logic             cfg_write;
  logic             reg_hit;

  logic             queue_full;
  logic             queue_not_empty;
  logic             push;
  logic             pop;
  result_t          push_item;
  result_t          head;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[ADDR_W-1:2] == REG_PAYLOAD_CAPACITY);
  assign cfg_write = psel && penable && pwrite && reg_hit;
  assign prdata    = reg_hit ? DATA_W'(payload_capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_capacity <= CAP_RESET;
    end else if (cfg_write) begin
      payload_capacity <= pwdata[CAP_W-1:0];
    end
  end

  ssh_pd_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_byte    (rx_byte),
    .rx_stall   (rx_stall),
    .queue_full (queue_full),
    .capacity   (payload_capacity),
    .push       (push),
    .item       (push_item)
  );

  ssh_pd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  ssh_pd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (queue_not_empty),
    .q_item          (head),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .payload_byte    (payload_byte),
    .last_of_payload (last_of_payload),
    .frame_error     (frame_error),
    .error_kind      (error_kind)
  );

endmodule
